// ----- rtl/pptb_pkg.sv -----
// Shared types, field widths and a helper function of the pre/post trigger trace buffer.
// Used by the channel interfaces and the top level.
package pptb_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int WORD_BITS_DEF   = 64;

    localparam int KIND_W    = 2;
    localparam int DATA_W    = 64;
    localparam int INDEX_W   = 10;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 11;
    localparam int CAP_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);
    localparam logic [CAP_W-1:0] POST_SAT  = {CAP_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH       = 2'd0,
        KIND_TRIGGER    = 2'd1,
        KIND_READ_ENTRY = 2'd2,
        KIND_READ_EVENT = 2'd3
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_RECORD = 2'd0,
        MODE_POST   = 2'd1,
        MODE_FROZEN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRE_CAPACITY  = 2'd0,
        REG_POST_CAPACITY = 2'd1,
        REG_UNUSED_2      = 2'd2,
        REG_UNUSED_3      = 2'd3
    } t_reg_idx;

    // A capacity of zero behaves as a capacity of one.
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        return (cap == '0) ? CAP_W'(1) : cap;
    endfunction

endpackage

// ----- rtl/pptb_ifs.sv -----
// Valid/ready channel interfaces of the trace buffer: input items, result items
// and configuration writes. Field types come from pptb_pkg.
interface pptb_in_if import pptb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [DATA_W-1:0]    sample_word;
    logic [DATA_W-1:0]    event_word;
    logic [INDEX_W-1:0]   read_index;

    modport source (output valid, kind, sample_word, event_word, read_index, input ready);
    modport sink   (input valid, kind, sample_word, event_word, read_index, output ready);
endinterface

interface pptb_out_if import pptb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_mode                mode;
    logic [COUNT_W-1:0]   entry_count;
    logic [DATA_W-1:0]    read_data;
    logic                 read_valid;
    logic                 event_held;

    modport source (output valid, mode, entry_count, read_data, read_valid, event_held,
                    input ready);
    modport sink   (input valid, mode, entry_count, read_data, read_valid, event_held,
                    output ready);
endinterface

interface pptb_cfg_if import pptb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_reg_idx               index;
    logic [CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pre_post_trigger_trace_buffer.sv -----
// Top level of the pre/post trigger trace buffer: ring pointer control, mode
// control, result register. Uses pptb_pkg, the channel interfaces and pptb_store.
//
// The buffer records sample words into a ring held in one synchronous memory,
// keeping at most pre_capacity of them until a trigger arrives; it then keeps
// each new sample, overwriting the oldest when full, until post_capacity
// further samples have come in and freezes. A push, a trigger or a read of
// the trigger event is answered directly, so such items can be accepted on
// every clock while results are taken. A read of an entry goes through the
// store, whose read data is registered; the input side is held off until
// its result is loaded. Each item gives exactly one result, held in an output
// register until taken. Configuration writes are taken at any time and should
// only be made while the block is idle. The store needs no clearing pass: only
// entries below the held count are ever returned, and all have been written.
module pre_post_trigger_trace_buffer import pptb_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pptb_in_if.sink   i_in,
    pptb_out_if.source o_out,
    pptb_cfg_if.sink  i_cfg
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W + 1 : INDEX_W + 1;

    localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(STORE_DEPTH - 1);

    // Control state.
    t_mode              r_mode, n_mode;
    logic [ADDR_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [CAP_W-1:0]   r_post, n_post;
    logic               r_event_present, n_event_present;
    logic [WORD_BITS-1:0] r_event, n_event;
    logic [CAP_W-1:0]   r_pre_cap, r_post_cap;
    logic               r_rd_pend;
    logic               r_rd_hit;

    // Result register.
    logic               r_out_valid;
    t_mode              r_out_mode;
    logic [COUNT_W-1:0] r_out_count;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_rvalid;
    logic               r_out_event;

    logic               accept;
    logic               out_free;
    logic               load_direct;
    logic               load_read;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [ADDR_W-1:0]  oldest_inc;
    logic [SUM_W-1:0]   wsum;
    logic [SUM_W-1:0]   rsum;
    logic [ADDR_W-1:0]  app_oldest;
    logic [CNT_W-1:0]   app_held;
    logic [ADDR_W-1:0]  app_oldest_inc;
    logic               idx_hit;
    logic [DATA_W-1:0]  direct_data;
    logic               direct_rvalid;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_rd_pend && out_free;
    assign accept      = i_in.valid && i_in.ready;
    assign load_direct = accept && (i_in.kind != KIND_READ_ENTRY);
    assign load_read   = r_rd_pend && out_free;
    assign i_cfg.ready = 1'b1;

    // Ring address arithmetic: every sum stays below twice the depth while the read index is below the depth.
    assign oldest_inc     = (r_oldest == LAST_A) ? '0 : r_oldest + ADDR_W'(1);
    assign wsum           = SUM_W'(r_oldest) + SUM_W'(r_held);
    assign rsum           = SUM_W'(r_oldest) + SUM_W'(i_in.read_index);
    assign app_oldest_inc = (app_oldest == LAST_A) ? '0 : app_oldest + ADDR_W'(1);
    assign idx_hit        = CMP_W'(i_in.read_index) < CMP_W'(r_held);

    // Append a sample: a full store overwrites its oldest entry.
    always_comb begin
        if (r_held >= DEPTH_C) begin
            mem_waddr  = r_oldest;
            app_oldest = oldest_inc;
            app_held   = DEPTH_C;
        end else begin
            mem_waddr  = (wsum >= DEPTH_S) ? ADDR_W'(wsum - DEPTH_S) : ADDR_W'(wsum);
            app_oldest = r_oldest;
            app_held   = r_held + CNT_W'(1);
        end
    end

    assign mem_raddr = (rsum >= DEPTH_S) ? ADDR_W'(rsum - DEPTH_S) : ADDR_W'(rsum);
    assign mem_re    = accept && (i_in.kind == KIND_READ_ENTRY);

    // Next state of the capture mode and ring pointers.
    always_comb begin
        n_mode          = r_mode;
        n_oldest        = r_oldest;
        n_held          = r_held;
        n_post          = r_post;
        n_event_present = r_event_present;
        n_event         = r_event;
        mem_we          = 1'b0;
        if (accept) begin
            case (i_in.kind)
                KIND_PUSH: begin
                    if (r_mode == MODE_RECORD) begin
                        mem_we = 1'b1;
                        if (CMP_W'(app_held) > CMP_W'(eff_cap(r_pre_cap))) begin
                            n_oldest = app_oldest_inc;
                            n_held   = app_held - CNT_W'(1);
                        end else begin
                            n_oldest = app_oldest;
                            n_held   = app_held;
                        end
                    end else if (r_mode == MODE_POST) begin
                        mem_we   = 1'b1;
                        n_oldest = app_oldest;
                        n_held   = app_held;
                        n_post   = (r_post != POST_SAT) ? r_post + CAP_W'(1) : r_post;
                        if (n_post >= eff_cap(r_post_cap)) begin
                            n_mode = MODE_FROZEN;
                        end
                    end
                end
                KIND_TRIGGER: begin
                    if (r_mode == MODE_RECORD) begin
                        n_event         = WORD_BITS'(i_in.event_word);
                        n_event_present = 1'b1;
                        n_mode          = MODE_POST;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result data of the items answered in the cycle they are accepted.
    always_comb begin
        direct_data   = '0;
        direct_rvalid = 1'b0;
        if (i_in.kind == KIND_READ_EVENT && r_event_present) begin
            direct_data   = DATA_W'(r_event);
            direct_rvalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_RECORD;
            r_oldest        <= '0;
            r_held          <= '0;
            r_post          <= '0;
            r_event_present <= 1'b0;
            r_event         <= '0;
            r_rd_pend       <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pre_cap       <= CAP_RESET;
            r_post_cap      <= CAP_RESET;
        end else begin
            r_mode          <= n_mode;
            r_oldest        <= n_oldest;
            r_held          <= n_held;
            r_post          <= n_post;
            r_event_present <= n_event_present;
            r_event         <= n_event;
            if (mem_re) begin
                r_rd_pend <= 1'b1;
            end else if (load_read) begin
                r_rd_pend <= 1'b0;
            end
            if (load_direct || load_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_PRE_CAPACITY:  r_pre_cap  <= i_cfg.data;
                    REG_POST_CAPACITY: r_post_cap <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_hit <= idx_hit;
        end
        // The mode, count and event flag after the update; a read leaves them alone.
        if (load_direct) begin
            r_out_mode   <= n_mode;
            r_out_count  <= COUNT_W'(n_held);
            r_out_data   <= direct_data;
            r_out_rvalid <= direct_rvalid;
            r_out_event  <= n_event_present;
        end else if (load_read) begin
            r_out_mode   <= r_mode;
            r_out_count  <= COUNT_W'(r_held);
            r_out_data   <= r_rd_hit ? DATA_W'(mem_rdata) : '0;
            r_out_rvalid <= r_rd_hit;
            r_out_event  <= r_event_present;
        end
    end

    // A write and a later read are never issued in the same cycle, so a write lands before any
    // later read and the store never needs forwarding.
    pptb_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (WORD_BITS'(i_in.sample_word)),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.mode        = r_out_mode;
    assign o_out.entry_count = r_out_count;
    assign o_out.read_data   = r_out_data;
    assign o_out.read_valid  = r_out_rvalid;
    assign o_out.event_held  = r_out_event;

    a_no_accept_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !i_in.ready)
        else $error("input accepted while an entry read is outstanding");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= DEPTH_C)
        else $error("held count exceeds the store depth");

    a_frozen_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FROZEN |=> r_mode == MODE_FROZEN)
        else $error("buffer left the frozen mode");

    a_event_with_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_event_present) |-> r_mode == MODE_POST)
        else $error("event captured without entering post-trigger recording");

    a_miss_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_rvalid) |-> r_out_data == '0)
        else $error("result without a hit carries non-zero data");

endmodule

// ----- rtl/pptb_store.sv -----
// Sample ring storage: one write port and one read port, read data registered.
// Depends on nothing but its parameters.
module pptb_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds until the next read, so a stalled result keeps it.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
